// ===== rtl/htpa_pkg.sv =====
// Shared types and constants for the HSL tint to premultiplied ARGB converter.
package htpa_pkg;

  // Width of one output colour channel and of alpha.
  localparam int CH_W = 8;

  // Configuration register index width and register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_HUE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_SAT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_LIGHT = 2'd2;

  // Hue sector of one channel: rising or falling ramp, top plateau, base plateau.
  typedef enum logic [1:0] {
    SEC_RAMP = 2'd0,
    SEC_TOP  = 2'd1,
    SEC_BASE = 2'd2
  } sector_t;

  // How a saturation or lightness tint acts on its component.
  typedef enum logic [1:0] {
    SHIFT_OFF   = 2'd0,
    SHIFT_SCALE = 2'd1,
    SHIFT_PUSH  = 2'd2
  } shift_mode_t;

endpackage

// ===== rtl/hsl_tint_to_premul_argb.sv =====
// Pipelined HSL tint and HSL to premultiplied ARGB conversion, top level.
//
// Takes one HSL pixel with alpha per clock and returns one premultiplied ARGB pixel
// for each, strobed by done for a single cycle; busy is always low, so a
// request is taken on every cycle that start is high. The eight register stages are
// the input capture, the tint multipliers, the tint adders, the lightness times
// saturation multiplier, the two-temp and hue-sector logic, the three ramp
// multipliers, the channel select and the alpha premultiply. Hue, saturation and
// lightness above one saturate to one. The three tint registers may be written
// only while no request is in flight, since the first two stages read them directly.
module hsl_tint_to_premul_argb #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic                           cfg_write,
  input  logic [htpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [FRACTION_BITS+1:0]       cfg_data,
  input  logic [FRACTION_BITS:0]         hue,
  input  logic [FRACTION_BITS:0]         saturation,
  input  logic [FRACTION_BITS:0]         lightness,
  input  logic [htpa_pkg::CH_W-1:0]      alpha,
  output logic [htpa_pkg::CH_W-1:0]      alpha_out,
  output logic [htpa_pkg::CH_W-1:0]      red,
  output logic [htpa_pkg::CH_W-1:0]      green,
  output logic [htpa_pkg::CH_W-1:0]      blue
);

  import htpa_pkg::*;

  localparam int W   = FRACTION_BITS + 1;     // component, 0 to one
  localparam int TW  = FRACTION_BITS + 2;     // two-temp values, up to two
  localparam int HW3 = FRACTION_BITS + 3;     // hue times three
  localparam int XW  = FRACTION_BITS + 4;     // signed shifted hue
  localparam int PW  = 2 * W;                 // component product
  localparam int DW  = TW + W;                // ramp product
  localparam int CW  = 10;                    // channel before premultiply
  localparam int LAT = 8;

  localparam logic [W-1:0]  ONE     = W'(1) << FRACTION_BITS;
  localparam logic [W-1:0]  HALF    = W'(1) << (FRACTION_BITS - 1);
  localparam logic [XW-1:0] ONE_X   = XW'(1) << FRACTION_BITS;
  localparam logic [XW-1:0] HALF_X  = XW'(1) << (FRACTION_BITS - 1);
  localparam logic [XW-1:0] THREE_X = XW'(3) << FRACTION_BITS;
  localparam logic [XW-1:0] THRH_X  = XW'(3) << (FRACTION_BITS - 1);
  localparam logic [XW-1:0] TWO_X   = XW'(2) << FRACTION_BITS;

  typedef struct packed {
    sector_t        sec;
    logic [W-1:0]   k;
  } chan_sect_t;

  // Place a shifted hue in its sector and give the ramp factor.
  function automatic chan_sect_t classify(input logic [XW-1:0] xin);
    logic [XW-1:0] x;
    chan_sect_t    r;
    x = xin;
    if (x[XW-1]) begin
      x = x + THREE_X;
    end else if (x > THREE_X) begin
      x = x - THREE_X;
    end
    r.k = '0;
    if (x < HALF_X) begin
      r.sec = SEC_RAMP;
      r.k   = W'({x, 1'b0});
    end else if (x < THRH_X) begin
      r.sec = SEC_TOP;
    end else if (x < TWO_X) begin
      r.sec = SEC_RAMP;
      r.k   = W'({TWO_X - x, 1'b0});
    end else begin
      r.sec = SEC_BASE;
    end
    return r;
  endfunction

  // Tint mode of a saturation or lightness register.
  function automatic shift_mode_t shift_mode(input logic on, input logic [W-1:0] sh);
    shift_mode_t m;
    if (!on) begin
      m = SHIFT_OFF;
    end else if (sh <= HALF) begin
      m = SHIFT_SCALE;
    end else begin
      m = SHIFT_PUSH;
    end
    return m;
  endfunction

  // Finish a tint from the registered product.
  function automatic logic [W-1:0] shift_done(input shift_mode_t m, input logic [W-1:0] comp,
                                              input logic [PW-1:0] prod);
    logic [W-1:0] frac;
    logic [W-1:0] r;
    frac = W'(prod >> FRACTION_BITS);
    case (m)
      SHIFT_SCALE: r = frac;
      SHIFT_PUSH:  r = comp + frac;
      default:     r = comp;
    endcase
    return r;
  endfunction

  // Tint registers.
  logic [2:0]   tint_on;
  logic [W-1:0] tint_val [3];
  logic         cfg_neg;
  logic [W-1:0] cfg_sat;

  assign cfg_neg = cfg_data[TW-1];
  assign cfg_sat = (cfg_data[W-1:0] > ONE) ? ONE : cfg_data[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tint_on  <= '0;
      tint_val <= '{default: '0};
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TINT_HUE: begin
          tint_on[0]  <= !cfg_neg;
          tint_val[0] <= cfg_neg ? '0 : cfg_sat;
        end
        REG_TINT_SAT: begin
          tint_on[1]  <= !cfg_neg;
          tint_val[1] <= cfg_neg ? '0 : cfg_sat;
        end
        REG_TINT_LIGHT: begin
          tint_on[2]  <= !cfg_neg;
          tint_val[2] <= cfg_neg ? '0 : cfg_sat;
        end
        default: begin
        end
      endcase
    end
  end

  // Valid bits travelling with the stages.
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

  assign busy = 1'b0;
  assign done = vld[LAT-1];

  // Stage 1: saturate the inputs and replace the hue.
  logic [W-1:0]      s1_hue, s1_sat, s1_light;
  logic [CH_W-1:0]   s1_alpha;
  logic [W-1:0]      hue_next;

  assign hue_next = tint_on[0] ? tint_val[0] : ((hue > ONE) ? ONE : hue);

  always_ff @(posedge clk) begin
    s1_hue   <= hue_next;
    s1_sat   <= (saturation > ONE) ? ONE : saturation;
    s1_light <= (lightness > ONE) ? ONE : lightness;
    s1_alpha <= alpha;
  end

  // Stage 2: tint multipliers for saturation and lightness.
  shift_mode_t     smode_next, lmode_next;
  logic [W:0]      ssh2, lsh2;
  logic [W-1:0]    sa, sb, la, lb;
  shift_mode_t     s2_smode, s2_lmode;
  logic [PW-1:0]   s2_sprod, s2_lprod;
  logic [W-1:0]    s2_hue, s2_sat, s2_light;
  logic [CH_W-1:0] s2_alpha;

  always_comb begin
    smode_next = shift_mode(tint_on[1], tint_val[1]);
    lmode_next = shift_mode(tint_on[2], tint_val[2]);
    ssh2 = {tint_val[1], 1'b0};
    lsh2 = {tint_val[2], 1'b0};
    sa = (smode_next == SHIFT_PUSH) ? ONE - s1_sat : s1_sat;
    sb = (smode_next == SHIFT_PUSH) ? W'(ssh2 - {1'b0, ONE}) : W'(ssh2);
    la = (lmode_next == SHIFT_PUSH) ? ONE - s1_light : s1_light;
    lb = (lmode_next == SHIFT_PUSH) ? W'(lsh2 - {1'b0, ONE}) : W'(lsh2);
  end

  always_ff @(posedge clk) begin
    s2_smode <= smode_next;
    s2_lmode <= lmode_next;
    s2_sprod <= sa * sb;
    s2_lprod <= la * lb;
    s2_hue   <= s1_hue;
    s2_sat   <= s1_sat;
    s2_light <= s1_light;
    s2_alpha <= s1_alpha;
  end

  // Stage 3: finish the tint.
  logic [W-1:0]    s3_hue, s3_sat, s3_light;
  logic [CH_W-1:0] s3_alpha;

  always_ff @(posedge clk) begin
    s3_hue   <= s2_hue;
    s3_sat   <= shift_done(s2_smode, s2_sat, s2_sprod);
    s3_light <= shift_done(s2_lmode, s2_light, s2_lprod);
    s3_alpha <= s2_alpha;
  end

  // Stage 4: lightness times saturation, hue in thirds of one.
  logic [PW-1:0]   s4_ls;
  logic [HW3-1:0]  s4_x3;
  logic [W-1:0]    s4_sat, s4_light;
  logic            s4_grey;
  logic [CH_W-1:0] s4_alpha;

  always_ff @(posedge clk) begin
    s4_ls    <= s3_light * s3_sat;
    s4_x3    <= HW3'({s3_hue, 1'b0}) + HW3'(s3_hue);
    s4_sat   <= s3_sat;
    s4_light <= s3_light;
    s4_grey  <= (s3_sat == '0);
    s4_alpha <= s3_alpha;
  end

  // Stage 5: the two temps, hue sectors and the grey level.
  logic [W-1:0]    ls;
  logic [TW-1:0]   l2, t2a, t2b, t1v, t2v;
  logic [XW-1:0]   xg;
  chan_sect_t      sect_next [3];
  logic [CH_W-1:0] lightc_next;

  always_comb begin
    ls  = W'(s4_ls >> FRACTION_BITS);
    l2  = {s4_light, 1'b0};
    if (s4_light < HALF) begin
      t2a = TW'(s4_light) + TW'(ls);
    end else begin
      t2a = TW'(s4_light) + TW'(s4_sat) - TW'(ls);
    end
    t2b = (t2a > l2) ? l2 : t2a;
    t1v = l2 - t2b;
    t2v = (t2b < t1v) ? t1v : t2b;
    xg  = XW'(s4_x3);
    sect_next[0] = classify(xg + ONE_X);
    sect_next[1] = classify(xg);
    sect_next[2] = classify(xg - ONE_X);
    lightc_next = (s4_light >= ONE) ? {CH_W{1'b1}} : CH_W'(s4_light >> (FRACTION_BITS - 8));
  end

  logic [TW-1:0]   s5_t1, s5_t2, s5_d;
  chan_sect_t      s5_sect [3];
  logic            s5_grey;
  logic [CH_W-1:0] s5_lightc, s5_alpha;

  always_ff @(posedge clk) begin
    s5_t1     <= t1v;
    s5_t2     <= t2v;
    s5_d      <= t2v - t1v;
    s5_sect   <= sect_next;
    s5_grey   <= s4_grey;
    s5_lightc <= lightc_next;
    s5_alpha  <= s4_alpha;
  end

  // Stage 6: ramp products for the three channels.
  logic [DW-1:0]   s6_prod [3];
  sector_t         s6_sec  [3];
  logic [TW-1:0]   s6_t1, s6_t2;
  logic            s6_grey;
  logic [CH_W-1:0] s6_lightc, s6_alpha;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s6_prod[i] <= s5_d * s5_sect[i].k;
      s6_sec[i]  <= s5_sect[i].sec;
    end
    s6_t1     <= s5_t1;
    s6_t2     <= s5_t2;
    s6_grey   <= s5_grey;
    s6_lightc <= s5_lightc;
    s6_alpha  <= s5_alpha;
  end

  // Stage 7: pick each channel value and scale it to eight integer bits.
  logic [TW-1:0]   chan_v [3];
  logic [CW-1:0]   chan_next [3];
  logic [CW-1:0]   s7_chan [3];
  logic            s7_grey;
  logic [CH_W-1:0] s7_alpha;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (s6_sec[i])
        SEC_RAMP: chan_v[i] = s6_t1 + TW'(s6_prod[i] >> FRACTION_BITS);
        SEC_TOP:  chan_v[i] = s6_t2;
        default:  chan_v[i] = s6_t1;
      endcase
      chan_next[i] = s6_grey ? CW'(s6_lightc) : CW'(chan_v[i] >> (FRACTION_BITS - 8));
    end
  end

  always_ff @(posedge clk) begin
    s7_chan  <= chan_next;
    s7_grey  <= s6_grey;
    s7_alpha <= s6_alpha;
  end

  // Stage 8: premultiply by alpha and saturate.
  logic [CH_W:0]        alpha_inc;
  logic [CW+CH_W:0]     pm [3];
  logic [CW+CH_W-8:0]   pm_sh [3];
  logic [CH_W-1:0]      pm_sat [3];
  logic                 s8_grey;

  always_comb begin
    alpha_inc = {1'b0, s7_alpha} + (CH_W+1)'(1);
    for (int i = 0; i < 3; i++) begin
      pm[i]     = s7_chan[i] * alpha_inc;
      pm_sh[i]  = pm[i][CW+CH_W:8];
      pm_sat[i] = (pm_sh[i] > (CW+CH_W-7)'(255)) ? {CH_W{1'b1}} : pm_sh[i][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    red       <= pm_sat[0];
    green     <= pm_sat[1];
    blue      <= pm_sat[2];
    alpha_out <= s7_alpha;
    s8_grey   <= s7_grey;
  end

  // Checks on the pipeline.
  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a request eight cycles before");

  a_alpha_passes: assert property (@(posedge clk) disable iff (rst)
    done |-> alpha_out == $past(alpha, LAT))
    else $error("alpha not carried with its request");

  a_temps_ordered: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> s6_t1 <= s6_t2)
    else $error("lower temp above upper temp");

  a_grey_equal: assert property (@(posedge clk) disable iff (rst)
    (done && s8_grey) |-> (red == green && green == blue))
    else $error("grey pixel with unequal channels");

endmodule

// ===== tb/hsl_tint_to_premul_argb_tb.sv =====
// Self-checking testbench for the HSL tint to premultiplied ARGB converter.
module hsl_tint_to_premul_argb_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htpa_pkg::*;

  localparam int FB = 16;
  localparam logic [63:0] UNIT = 64'd1 << FB;
  localparam logic [63:0] HALF = UNIT >> 1;
  localparam longint UNIT_S = longint'(1) << FB;
  localparam logic [FB+1:0] TINT_OFF = '1;
  // Index beyond the three tint registers; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] alpha_out;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } argb_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 done;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FB+1:0]        cfg_data;
  logic [FB:0]          hue;
  logic [FB:0]          saturation;
  logic [FB:0]          lightness;
  logic [CH_W-1:0]      alpha;
  logic [CH_W-1:0]      alpha_out;
  logic [CH_W-1:0]      red;
  logic [CH_W-1:0]      green;
  logic [CH_W-1:0]      blue;

  // Pixels predicted for accepted requests, oldest first.
  argb_t       expected_pixels[$];
  int          mismatches = 0;
  int          idle_pct = 0;
  // Local copy of the three tint registers.
  bit          tint_on[3];
  logic [63:0] tint_level[3];

  always #5 clk = ~clk;

  hsl_tint_to_premul_argb #(
    .FRACTION_BITS(FB)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .done(done),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .hue(hue),
    .saturation(saturation),
    .lightness(lightness),
    .alpha(alpha),
    .alpha_out(alpha_out),
    .red(red),
    .green(green),
    .blue(blue)
  );

  function automatic logic [63:0] clamp_unit(input logic [63:0] v);
    return (v > UNIT) ? UNIT : v;
  endfunction

  // Scale a component down at or below one half, push it toward one above.
  function automatic logic [63:0] tint_shift(input logic [63:0] comp, input logic [63:0] level);
    shift_mode_t mode;
    mode = (level <= HALF) ? SHIFT_SCALE : SHIFT_PUSH;
    if (mode == SHIFT_SCALE) begin
      return (comp * (level * 2)) >> FB;
    end
    return comp + (((UNIT - comp) * (level * 2 - UNIT)) >> FB);
  endfunction

  // Channel level for a hue position given in units of one third of a turn.
  function automatic logic [63:0] ramp_level(input logic [63:0] t1, input logic [63:0] t2,
                                             input longint pos);
    sector_t     sec;
    logic [63:0] u;
    logic [63:0] span;
    span = '0;
    if (pos < 0) begin
      pos += 3 * UNIT_S;
    end else if (pos > 3 * UNIT_S) begin
      pos -= 3 * UNIT_S;
    end
    u = pos;
    if (u * 2 < UNIT) begin
      sec  = SEC_RAMP;
      span = u;
    end else if (u * 2 < 3 * UNIT) begin
      sec = SEC_TOP;
    end else if (u < 2 * UNIT) begin
      sec  = SEC_RAMP;
      span = 2 * UNIT - u;
    end else begin
      sec = SEC_BASE;
    end
    case (sec)
      SEC_RAMP: return t1 + (((t2 - t1) * 2 * span) >> FB);
      SEC_TOP:  return t2;
      default:  return t1;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] premultiply(input logic [63:0] c, input logic [7:0] a);
    logic [63:0] p;
    p = (c * (64'(a) + 1)) >> 8;
    return (p > 255) ? 8'd255 : p[7:0];
  endfunction

  // Expected output pixel for one request under the current tint settings.
  function automatic argb_t predict_argb(input logic [FB:0] h_in, input logic [FB:0] s_in,
                                         input logic [FB:0] l_in, input logic [7:0] a);
    argb_t       px;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] l;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] grey;
    longint      pos;
    h = clamp_unit(64'(h_in));
    s = clamp_unit(64'(s_in));
    l = clamp_unit(64'(l_in));
    if (tint_on[REG_TINT_HUE]) h = tint_level[REG_TINT_HUE];
    if (tint_on[REG_TINT_SAT]) s = tint_shift(s, tint_level[REG_TINT_SAT]);
    if (tint_on[REG_TINT_LIGHT]) l = tint_shift(l, tint_level[REG_TINT_LIGHT]);
    px.alpha_out = a;
    if (s == 0) begin
      // Grey: white is clipped to 255 before premultiplying.
      grey = (l >= UNIT) ? 64'd255 : (l >> (FB - 8));
      px.red   = premultiply(grey, a);
      px.green = px.red;
      px.blue  = px.red;
    end else begin
      if (l < HALF) begin
        t2 = l + ((l * s) >> FB);
      end else begin
        t2 = l + s - ((l * s) >> FB);
      end
      if (t2 > 2 * l) t2 = 2 * l;
      t1 = 2 * l - t2;
      if (t2 < t1) t2 = t1;
      pos = 3 * longint'(h);
      px.red   = premultiply(ramp_level(t1, t2, pos + UNIT_S) >> (FB - 8), a);
      px.green = premultiply(ramp_level(t1, t2, pos) >> (FB - 8), a);
      px.blue  = premultiply(ramp_level(t1, t2, pos - UNIT_S) >> (FB - 8), a);
    end
    return px;
  endfunction

  // Mostly in-range components, with the ends and out-of-range codes mixed in.
  function automatic logic [FB:0] rand_component();
    case ($urandom_range(9))
      0:       return '0;
      1:       return UNIT[FB:0];
      2:       return (FB + 1)'($urandom_range((1 << (FB + 1)) - 1));
      default: return (FB + 1)'($urandom_range(32'(UNIT)));
    endcase
  endfunction

  function automatic logic [FB+1:0] rand_tint();
    case ($urandom_range(7))
      0:       return TINT_OFF;
      1:       return {1'b1, (FB + 1)'($urandom)};
      2:       return '0;
      3:       return HALF[FB+1:0];
      4:       return UNIT[FB+1:0];
      5:       return (FB + 2)'($urandom_range((1 << (FB + 1)) - 1, 32'(UNIT) + 1));
      default: return (FB + 2)'($urandom_range(32'(UNIT)));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Present one request, with random idle cycles first, and record its prediction.
  task automatic send_pixel(input logic [FB:0] h, input logic [FB:0] s, input logic [FB:0] l,
                            input logic [7:0] a);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start      <= 1'b0;
      hue        <= (FB + 1)'($urandom);
      saturation <= (FB + 1)'($urandom);
      lightness  <= (FB + 1)'($urandom);
      alpha      <= 8'($urandom);
      @(posedge clk);
    end
    start      <= 1'b1;
    hue        <= h;
    saturation <= s;
    lightness  <= l;
    alpha      <= a;
    do @(posedge clk); while (busy);
    expected_pixels.push_back(predict_argb(h, s, l, a));
  endtask

  // Stop requesting and wait until every outstanding pixel has come back.
  task automatic drain_requests();
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_tint(input logic [CFG_IDX_W-1:0] idx, input logic [FB+1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx <= REG_TINT_LIGHT) begin
      tint_on[idx]    = !data[FB+1];
      tint_level[idx] = data[FB+1] ? 64'd0 : clamp_unit(64'(data));
    end
  endtask

  task automatic set_tints(input logic [FB+1:0] h, input logic [FB+1:0] s,
                           input logic [FB+1:0] l);
    drain_requests();
    write_tint(REG_TINT_HUE, h);
    write_tint(REG_TINT_SAT, s);
    write_tint(REG_TINT_LIGHT, l);
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(rand_component(), rand_component(), rand_component(),
                              8'($urandom_range(255)));
  endtask

  // Field extremes, sector boundaries, grey and channel saturation with tints off.
  task automatic test_directed();
    idle_pct = 0;
    send_pixel('0, '0, '0, 8'd0);
    send_pixel(UNIT[FB:0], UNIT[FB:0], UNIT[FB:0], 8'd255);
    send_pixel('1, '1, '1, 8'd255);
    send_pixel('0, '0, UNIT[FB:0], 8'd255);
    send_pixel(17'd12345, '0, 17'd40000, 8'd128);
    send_pixel('0, UNIT[FB:0], HALF[FB:0], 8'd255);
    send_pixel(17'd10922, UNIT[FB:0], HALF[FB:0], 8'd200);
    send_pixel(17'd10923, UNIT[FB:0], HALF[FB:0], 8'd200);
    send_pixel(17'd21845, UNIT[FB:0], HALF[FB:0], 8'd255);
    send_pixel(17'd32768, UNIT[FB:0], HALF[FB:0], 8'd255);
    send_pixel(17'd43690, UNIT[FB:0], HALF[FB:0], 8'd255);
    send_pixel(17'd43691, UNIT[FB:0], HALF[FB:0], 8'd255);
    send_pixel(17'd65535, UNIT[FB:0], HALF[FB:0], 8'd255);
    send_pixel(UNIT[FB:0], 17'd30000, 17'd20000, 8'd77);
    send_pixel(17'd5000, 17'd30000, 17'd50000, 8'd1);
    send_pixel(17'd60000, 17'd1, 17'd1, 8'd255);
    send_pixel(17'h15555, 17'h0AAAA, 17'h15555, 8'h55);
    send_pixel(17'h0AAAA, 17'h15555, 17'h0AAAA, 8'hAA);
  endtask

  // Each tint register through off, zero, neutral, one, above one and negative codes.
  task automatic test_tint_settings();
    idle_pct = 0;
    set_tints(TINT_OFF, HALF[FB+1:0], HALF[FB+1:0]);
    send_random_pixels(8);
    set_tints('0, '0, '0);
    send_random_pixels(8);
    set_tints(UNIT[FB+1:0], UNIT[FB+1:0], UNIT[FB+1:0]);
    send_random_pixels(8);
    set_tints(18'h1FFFF, 18'h1FFFF, 18'h10001);
    send_random_pixels(8);
    set_tints(HALF[FB+1:0], 18'h20000, HALF[FB+1:0] + (FB + 2)'(1));
    send_random_pixels(8);
    set_tints(18'd21845, 18'd16384, 18'd49152);
    // A write to the spare index must leave the tints as they are.
    write_tint(REG_SPARE, '0);
    send_random_pixels(8);
    set_tints(TINT_OFF, TINT_OFF, TINT_OFF);
    send_random_pixels(8);
  endtask

  // Random pixels under random tints, retuned every 25 requests.
  task automatic test_random_traffic(input int pct, input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      set_tints(rand_tint(), rand_tint(), rand_tint());
      idle_pct = pct;
      send_random_pixels(25);
      sent += 25;
    end
  endtask

  // Compare each strobed pixel with the oldest prediction.
  always @(posedge clk) begin
    argb_t want;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel with no request outstanding, red", int'(red), 0);
      end else begin
        want = expected_pixels.pop_front();
        if (alpha_out !== want.alpha_out) begin
          report_mismatch("alpha_out", int'(alpha_out), int'(want.alpha_out));
        end
        if (red !== want.red) report_mismatch("red", int'(red), int'(want.red));
        if (green !== want.green) report_mismatch("green", int'(green), int'(want.green));
        if (blue !== want.blue) report_mismatch("blue", int'(blue), int'(want.blue));
      end
    end
  end

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    cfg_write  <= 1'b0;
    cfg_index  <= REG_TINT_HUE;
    cfg_data   <= '0;
    hue        <= '0;
    saturation <= '0;
    lightness  <= '0;
    alpha      <= '0;
    for (int i = 0; i < 3; i++) begin
      tint_on[i]    = 1'b0;
      tint_level[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_tint_settings();
    test_random_traffic(0, 100);
    test_random_traffic(65, 125);
    test_random_traffic(34, 125);
    test_random_traffic(0, 50);
    drain_requests();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/htpa_pkg.sv
rtl/hsl_tint_to_premul_argb.sv
tb/hsl_tint_to_premul_argb_tb.sv
